@@ rtl/core/crc16_framed_byte_deframer_assert.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef CRC16_FRAMED_BYTE_DEFRAMER_ASSERT_SVH
`define CRC16_FRAMED_BYTE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while reset is asserted
`define CFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

@@ rtl/core/cfd_pkg.sv @@
package cfd_pkg;

    // Frame geometry
    localparam int HEADER_BYTES    = 4;
    localparam int MAX_FRAME_BYTES = 256;
    localparam int FILL_W          = $clog2(MAX_FRAME_BYTES + 1);
    localparam int MSG_W           = (FILL_W > 9) ? FILL_W + 1 : 10;
    localparam int LEN_W           = 9;
    localparam int CNT_W           = 16;

    // Start bytes
    localparam logic [7:0] MAGIC_FIRST  = 8'h01;
    localparam logic [7:0] MAGIC_SEC_A  = 8'h64;
    localparam logic [7:0] MAGIC_SEC_B  = 8'h65;

    // CRC-16 (Modbus)
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Event queue depth, a power of two
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [2:0] {
        EV_OK      = 3'd0,
        EV_DROPPED = 3'd1,
        EV_CRC     = 3'd2,
        EV_LONG    = 3'd3,
        EV_FULL    = 3'd4
    } t_ev_code;

    typedef struct packed {
        t_ev_code            code;
        logic [FILL_W-1:0]   len;
    } t_event;

    typedef struct packed {
        logic [CNT_W-1:0] frames_ok;
        logic [CNT_W-1:0] magic_errors;
        logic [CNT_W-1:0] crc_errors;
        logic [CNT_W-1:0] length_errors;
        logic [CNT_W-1:0] full_errors;
    } t_counters;

    // Everything one byte produces: up to two events plus counter snapshot
    typedef struct packed {
        logic [1:0] cnt;
        t_event     ev0;
        t_event     ev1;
        t_counters  ctrs;
    } t_step;

    typedef struct packed {
        logic            empty;
        logic            full;
        logic [Q_AW:0]   count;
    } t_q_status;

    // One byte through the reflected CRC, bit by bit
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Append an event; anything past the second is dropped
    function automatic t_step step_emit(input t_step s, input t_ev_code code,
                                        input logic [FILL_W-1:0] len);
        t_step r;
        r = s;
        if (s.cnt == 2'd0) begin
            r.ev0.code = code;
            r.ev0.len  = len;
            r.cnt      = 2'd1;
        end else if (s.cnt == 2'd1) begin
            r.ev1.code = code;
            r.ev1.len  = len;
            r.cnt      = 2'd2;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/cfd_front.sv @@
module cfd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rx_valid,
    input  logic [7:0]           i_rx_byte,
    input  cfd_pkg::t_q_status   i_q_status,
    output logic                 o_rx_ready,
    output logic                 o_step_valid,
    output cfd_pkg::t_step       o_step
);

    // Frame state
    logic [cfd_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [cfd_pkg::FILL_W-1:0] r_drop, n_drop;
    logic [7:0]                 r_plen, n_plen;
    logic [15:0]                r_crc, n_crc;
    logic [15:0]                r_d1, n_d1;
    logic [15:0]                n_d2;
    logic [7:0]                 r_low, n_low;
    cfd_pkg::t_counters         r_ctrs, n_ctrs;

    logic                       w_accept;
    cfd_pkg::t_step             w_step;

    assign o_rx_ready   = !i_q_status.full;
    assign w_accept     = i_rx_valid && o_rx_ready;
    assign o_step_valid = w_accept && (w_step.cnt != 2'd0);
    assign o_step       = w_step;

    // Byte classification and next frame state
    always_comb begin
        logic                       full;
        logic                       clear;
        logic                       match;
        logic [cfd_pkg::FILL_W-1:0] f_base;
        logic [15:0]                crc_base;
        logic [15:0]                d1_base;
        logic [7:0]                 low_base;
        logic [7:0]                 plen_base;
        logic [7:0]                 prev;
        logic [cfd_pkg::MSG_W-1:0]  msg_end;
        w_step = '0;
        n_ctrs = r_ctrs;

        full      = r_fill >= cfd_pkg::FILL_W'(cfd_pkg::MAX_FRAME_BYTES);
        f_base    = r_fill;
        crc_base  = r_crc;
        d1_base   = r_d1;
        low_base  = r_low;
        plen_base = r_plen;
        clear     = 1'b0;

        // Buffer overflow: report and restart with this byte
        if (full) begin
            w_step = cfd_pkg::step_emit(w_step, cfd_pkg::EV_FULL, r_fill);
            n_ctrs.full_errors = n_ctrs.full_errors + 16'd1;
            f_base    = '0;
            crc_base  = cfd_pkg::CRC_INIT;
            d1_base   = cfd_pkg::CRC_INIT;
            low_base  = 8'h00;
            plen_base = 8'h00;
        end

        prev   = low_base;
        n_d2   = d1_base;
        n_d1   = crc_base;
        n_crc  = cfd_pkg::crc_add(crc_base, i_rx_byte);
        n_low  = i_rx_byte;
        n_fill = f_base + cfd_pkg::FILL_W'(1);
        n_plen = (n_fill == cfd_pkg::FILL_W'(cfd_pkg::HEADER_BYTES + 1)) ? i_rx_byte
                                                                          : plen_base;
        n_drop = r_drop;
        match  = ({i_rx_byte, prev} == n_d2);
        msg_end = cfd_pkg::MSG_W'(cfd_pkg::HEADER_BYTES + 3) + cfd_pkg::MSG_W'(n_plen);

        // Long dropped run is flushed before anything else
        if (n_drop > cfd_pkg::FILL_W'(cfd_pkg::MAX_FRAME_BYTES - 2)) begin
            w_step = cfd_pkg::step_emit(w_step, cfd_pkg::EV_DROPPED, n_drop);
            n_drop = '0;
        end

        if (n_fill == cfd_pkg::FILL_W'(1) && i_rx_byte != cfd_pkg::MAGIC_FIRST) begin
            n_drop = n_drop + cfd_pkg::FILL_W'(1);
            n_ctrs.magic_errors = n_ctrs.magic_errors + 16'd1;
            clear = 1'b1;
        end else if (n_fill == cfd_pkg::FILL_W'(2) && i_rx_byte != cfd_pkg::MAGIC_SEC_A &&
                     i_rx_byte != cfd_pkg::MAGIC_SEC_B) begin
            // both start bytes go to the dropped run
            n_drop = n_drop + cfd_pkg::FILL_W'(2);
            n_ctrs.magic_errors = n_ctrs.magic_errors + 16'd1;
            clear = 1'b1;
        end else begin
            if (n_drop != '0) begin
                w_step = cfd_pkg::step_emit(w_step, cfd_pkg::EV_DROPPED, n_drop);
                n_drop = '0;
            end
            if (n_fill >= cfd_pkg::FILL_W'(cfd_pkg::HEADER_BYTES + 2)) begin
                if (n_fill == cfd_pkg::FILL_W'(cfd_pkg::HEADER_BYTES + 2) && match) begin
                    // header-only frame
                    w_step = cfd_pkg::step_emit(w_step, cfd_pkg::EV_OK, n_fill);
                    n_ctrs.frames_ok = n_ctrs.frames_ok + 16'd1;
                    clear = 1'b1;
                end else if (msg_end > cfd_pkg::MSG_W'(cfd_pkg::MAX_FRAME_BYTES)) begin
                    w_step = cfd_pkg::step_emit(w_step, cfd_pkg::EV_LONG, n_fill);
                    n_ctrs.length_errors = n_ctrs.length_errors + 16'd1;
                    clear = 1'b1;
                end else if (cfd_pkg::MSG_W'(n_fill) >= msg_end) begin
                    if (!match) begin
                        w_step = cfd_pkg::step_emit(w_step, cfd_pkg::EV_CRC, n_fill);
                        n_ctrs.crc_errors = n_ctrs.crc_errors + 16'd1;
                    end else begin
                        w_step = cfd_pkg::step_emit(w_step, cfd_pkg::EV_OK, n_fill);
                        n_ctrs.frames_ok = n_ctrs.frames_ok + 16'd1;
                    end
                    clear = 1'b1;
                end
            end
        end

        if (clear) begin
            n_fill = '0;
            n_plen = 8'h00;
            n_crc  = cfd_pkg::CRC_INIT;
            n_d1   = cfd_pkg::CRC_INIT;
            n_low  = 8'h00;
        end

        w_step.ctrs = n_ctrs;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_drop <= '0;
            r_plen <= 8'h00;
            r_crc  <= cfd_pkg::CRC_INIT;
            r_d1   <= cfd_pkg::CRC_INIT;
            r_low  <= 8'h00;
            r_ctrs <= '0;
        end else if (w_accept) begin
            r_fill <= n_fill;
            r_drop <= n_drop;
            r_plen <= n_plen;
            r_crc  <= n_crc;
            r_d1   <= n_d1;
            r_low  <= n_low;
            r_ctrs <= n_ctrs;
        end
    end

endmodule

@@ rtl/core/cfd_queue.sv @@
module cfd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cfd_pkg::t_step       i_step,
    input  logic                 i_pop,
    output cfd_pkg::t_step       o_head,
    output cfd_pkg::t_q_status   o_status
);

    cfd_pkg::t_step              r_mem [cfd_pkg::Q_DEPTH];
    logic [cfd_pkg::Q_AW-1:0]    r_wr, n_wr;
    logic [cfd_pkg::Q_AW-1:0]    r_rd, n_rd;
    logic [cfd_pkg::Q_AW:0]      r_count, n_count;
    logic                        w_push;
    logic                        w_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (cfd_pkg::Q_AW + 1)'(cfd_pkg::Q_DEPTH));
    assign o_status.count = r_count;
    assign o_head         = r_mem[r_rd];

    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    // Pointer and occupancy update
    always_comb begin
        n_wr    = r_wr + (w_push ? cfd_pkg::Q_AW'(1) : '0);
        n_rd    = r_rd + (w_pop ? cfd_pkg::Q_AW'(1) : '0);
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + (cfd_pkg::Q_AW + 1)'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - (cfd_pkg::Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_step;
        end
    end

endmodule

@@ rtl/core/cfd_back.sv @@
module cfd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cfd_pkg::t_step              i_head,
    input  cfd_pkg::t_q_status          i_q_status,
    input  logic                        i_ev_ready,
    output logic                        o_pop,
    output logic                        o_ev_valid,
    output logic [2:0]                  o_event_res,
    output logic [cfd_pkg::LEN_W-1:0]   o_length,
    output logic                        o_last,
    output cfd_pkg::t_counters          o_ctrs
);

    // Which event of the head entry is on the port
    logic           r_idx, n_idx;
    cfd_pkg::t_event w_sel;
    logic           w_xfer;

    assign w_sel       = r_idx ? i_head.ev1 : i_head.ev0;
    assign o_ev_valid  = !i_q_status.empty;
    assign o_event_res = w_sel.code;
    assign o_length    = cfd_pkg::LEN_W'(w_sel.len);
    assign o_last      = r_idx || (i_head.cnt == 2'd1);
    assign o_ctrs      = i_head.ctrs;
    assign w_xfer      = o_ev_valid && i_ev_ready;
    assign o_pop       = w_xfer && o_last;

    always_comb begin
        n_idx = r_idx;
        if (w_xfer) begin
            n_idx = !o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 1'b0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

@@ rtl/core/crc16_framed_byte_deframer.sv @@
// Channel   Direction  Handshake                    Payload
// rx        in         i_rx_valid / o_rx_ready      i_rx_byte
// event     out        o_ev_valid / i_ev_ready      o_event_res, o_length, o_last, counters
//
// One byte is taken per cycle; CRC, start-byte and length checks finish in that cycle.
// A byte that raises two events holds the event port for two transfers; a four-entry
// queue between classifier and event port absorbs that and output stalls.
// o_rx_ready drops only while the queue is full.
// Reset (i_rst_n low, synchronous) empties the frame, dropped run, counters and queue.
`include "crc16_framed_byte_deframer_assert.svh"

module crc16_framed_byte_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_ev_valid,
    input  logic        i_ev_ready,
    output logic [2:0]  o_event_res,
    output logic [8:0]  o_length,
    output logic        o_last,
    output logic [15:0] o_frames_ok,
    output logic [15:0] o_magic_errors,
    output logic [15:0] o_crc_errors,
    output logic [15:0] o_length_errors,
    output logic [15:0] o_full_errors
);

    logic                 w_push;
    logic                 w_pop;
    cfd_pkg::t_step       w_step;
    cfd_pkg::t_step       w_head;
    cfd_pkg::t_q_status   w_q_status;
    cfd_pkg::t_counters   w_ctrs;

    // Byte classification and frame tracking
    cfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .i_rx_byte    (i_rx_byte),
        .i_q_status   (w_q_status),
        .o_rx_ready   (o_rx_ready),
        .o_step_valid (w_push),
        .o_step       (w_step)
    );

    // Event queue
    cfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_step   (w_step),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // Event port sequencing
    cfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_status  (w_q_status),
        .i_ev_ready  (i_ev_ready),
        .o_pop       (w_pop),
        .o_ev_valid  (o_ev_valid),
        .o_event_res (o_event_res),
        .o_length    (o_length),
        .o_last      (o_last),
        .o_ctrs      (w_ctrs)
    );

    assign o_frames_ok     = w_ctrs.frames_ok;
    assign o_magic_errors  = w_ctrs.magic_errors;
    assign o_crc_errors    = w_ctrs.crc_errors;
    assign o_length_errors = w_ctrs.length_errors;
    assign o_full_errors   = w_ctrs.full_errors;

    // Checks
    `CFD_ASSERT_NOW(a_q_bound, i_clk, i_rst_n, 1'b1,
        w_q_status.count <= (cfd_pkg::Q_AW + 1)'(cfd_pkg::Q_DEPTH))
    `CFD_ASSERT_NEXT(a_q_grow, i_clk, i_rst_n, w_push && !w_pop,
        w_q_status.count == $past(w_q_status.count) + (cfd_pkg::Q_AW + 1)'(1))
    `CFD_ASSERT_NOW(a_empty_idle, i_clk, i_rst_n, w_q_status.empty, !o_ev_valid)
    `CFD_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, !o_rx_ready, w_q_status.full)

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    // Directed table row: a literal byte or one half of the running CRC
    typedef enum logic [1:0] {
        B_LIT,
        B_CRC_LO,
        B_CRC_HI
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [7:0]         val;
        logic               sof;
        logic               chk;
        cfd_pkg::t_ev_code  code;
        logic [8:0]         len;
    } t_row;

    // One expected event transfer
    typedef struct packed {
        cfd_pkg::t_ev_code code;
        logic [8:0]  len;
        logic        last;
        logic [15:0] n_ok;
        logic [15:0] n_magic;
        logic [15:0] n_crc;
        logic [15:0] n_toolong;
        logic [15:0] n_full;
    } t_ev_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_ev_valid;
    logic        i_ev_ready = 1'b0;
    logic [2:0]  o_event_res;
    logic [8:0]  o_length;
    logic        o_last;
    logic [15:0] o_frames_ok;
    logic [15:0] o_magic_errors;
    logic [15:0] o_crc_errors;
    logic [15:0] o_length_errors;
    logic [15:0] o_full_errors;

    crc16_framed_byte_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_ev_valid      (o_ev_valid),
        .i_ev_ready      (i_ev_ready),
        .o_event_res     (o_event_res),
        .o_length        (o_length),
        .o_last          (o_last),
        .o_frames_ok     (o_frames_ok),
        .o_magic_errors  (o_magic_errors),
        .o_crc_errors    (o_crc_errors),
        .o_length_errors (o_length_errors),
        .o_full_errors   (o_full_errors)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Deframer shadow state
    int          fill;
    int          dropped;
    logic [7:0]  plen;
    logic [7:0]  last_byte;
    logic [15:0] crc_all;
    logic [15:0] crc_but1;
    logic [15:0] crc_but2;
    logic [15:0] cnt_ok;
    logic [15:0] cnt_magic;
    logic [15:0] cnt_crc;
    logic [15:0] cnt_toolong;
    logic [15:0] cnt_full;

    // Events raised by the byte being classified
    cfd_pkg::t_ev_code step_code [2];
    logic [8:0]  step_len [2];
    int          step_n;

    t_ev_rec     due_events[$];
    int          n_pushed = 0;
    int          n_checked = 0;
    int          n_fail = 0;
    int          n_bytes = 0;
    int          burst_left = 0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;

    t_row        dir_rows[$];
    logic [7:0]  pkt_q[$];
    logic [15:0] pkt_crc;
    t_ev_rec     want_ev;

    // Modbus CRC-16, reflected, one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    task automatic note_event(input cfd_pkg::t_ev_code code, input int len);
        if (step_n < 2) begin
            step_code[step_n] = code;
            step_len[step_n] = len[8:0];
            step_n++;
        end
    endtask

    task automatic restart_frame();
        fill = 0;
        plen = 8'h00;
        crc_all = cfd_pkg::CRC_INIT;
        crc_but1 = cfd_pkg::CRC_INIT;
        crc_but2 = cfd_pkg::CRC_INIT;
        last_byte = 8'h00;
    endtask

    // Start-byte, length and CRC decisions for the newest byte
    task automatic classify(input logic [7:0] b, input logic [7:0] prev);
        int   msg;
        logic match;
        if (dropped > cfd_pkg::MAX_FRAME_BYTES - 2) begin
            note_event(cfd_pkg::EV_DROPPED, dropped);
            dropped = 0;
        end
        if (fill == 1 && b != cfd_pkg::MAGIC_FIRST) begin
            dropped += 1;
            cnt_magic++;
            restart_frame();
            return;
        end
        if (fill == 2 && b != cfd_pkg::MAGIC_SEC_A && b != cfd_pkg::MAGIC_SEC_B) begin
            dropped += 2;
            cnt_magic++;
            restart_frame();
            return;
        end
        if (dropped > 0) begin
            note_event(cfd_pkg::EV_DROPPED, dropped);
            dropped = 0;
        end
        if (fill < cfd_pkg::HEADER_BYTES + 2) return;
        match = ({b, prev} == crc_but2);
        // header-only frame with a good CRC
        if (fill == cfd_pkg::HEADER_BYTES + 2 && match) begin
            cnt_ok++;
            note_event(cfd_pkg::EV_OK, fill);
            restart_frame();
            return;
        end
        msg = cfd_pkg::HEADER_BYTES + 1 + int'(plen);
        if (msg + 2 > cfd_pkg::MAX_FRAME_BYTES) begin
            cnt_toolong++;
            note_event(cfd_pkg::EV_LONG, fill);
            restart_frame();
            return;
        end
        if (fill < msg + 2) return;
        if (!match) begin
            cnt_crc++;
            note_event(cfd_pkg::EV_CRC, fill);
        end else begin
            cnt_ok++;
            note_event(cfd_pkg::EV_OK, fill);
        end
        restart_frame();
    endtask

    // Predict the events one accepted byte causes and queue them
    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] prev;
        t_ev_rec    e;
        step_n = 0;
        if (fill >= cfd_pkg::MAX_FRAME_BYTES) begin
            note_event(cfd_pkg::EV_FULL, fill);
            cnt_full++;
            restart_frame();
        end
        prev = last_byte;
        crc_but2 = crc_but1;
        crc_but1 = crc_all;
        crc_all = crc16_step(crc_all, b);
        last_byte = b;
        fill++;
        if (fill == cfd_pkg::HEADER_BYTES + 1) plen = b;
        classify(b, prev);
        for (int k = 0; k < step_n; k++) begin
            e.code = step_code[k];
            e.len = step_len[k];
            e.last = (k == step_n - 1);
            e.n_ok = cnt_ok;
            e.n_magic = cnt_magic;
            e.n_crc = cnt_crc;
            e.n_toolong = cnt_toolong;
            e.n_full = cnt_full;
            due_events.push_back(e);
            n_pushed++;
        end
    endtask

    task automatic mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        n_fail++;
    endtask

    // Offer one byte on rx, honoring the burst/gap pattern, and predict on transfer
    task automatic offer_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_rx_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge i_clk);
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        deframe_byte(b);
        n_bytes++;
        if (n_bytes == 400) hold_req = 1'b1;
    endtask

    task automatic add_row(input t_row_kind kind, input logic [7:0] val, input logic sof,
                           input logic chk, input cfd_pkg::t_ev_code code, input int len);
        t_row r;
        r.kind = kind;
        r.val = val;
        r.sof = sof;
        r.chk = chk;
        r.code = code;
        r.len = len[8:0];
        dir_rows.push_back(r);
    endtask

    task automatic pkt_put(input logic [7:0] b);
        pkt_q.push_back(b);
        pkt_crc = crc16_step(pkt_crc, b);
    endtask

    task automatic pkt_header();
        pkt_q.delete();
        pkt_crc = cfd_pkg::CRC_INIT;
        pkt_put(cfd_pkg::MAGIC_FIRST);
        pkt_put($urandom_range(0, 1) ? cfd_pkg::MAGIC_SEC_A : cfd_pkg::MAGIC_SEC_B);
        pkt_put(8'($urandom_range(0, 255)));
        pkt_put(8'($urandom_range(0, 255)));
    endtask

    // One random chunk of stream: mostly frames, some broken, some noise
    task automatic random_piece(input int piece);
        int sel;
        int pl;
        int n_send;
        int k;
        sel = $urandom_range(0, 99);
        if (piece == 20) begin
            // largest frame that fits the buffer
            pkt_header();
            pkt_put(8'd249);
            repeat (249) pkt_put(8'($urandom_range(0, 255)));
            pkt_q.push_back(pkt_crc[7:0]);
            pkt_q.push_back(pkt_crc[15:8]);
        end else if (piece == 40) begin
            // dropped run long enough to be flushed on its own
            pkt_q.delete();
            repeat (258) pkt_q.push_back(8'($urandom_range(2, 255)));
        end else if (sel < 80) begin
            pkt_header();
            if (sel < 8) begin
                pkt_q.push_back(pkt_crc[7:0]);
                pkt_q.push_back(pkt_crc[15:8]);
            end else if (sel < 16) begin
                pkt_put(8'($urandom_range(250, 255)));
                pkt_put(8'($urandom_range(0, 255)));
            end else begin
                pl = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 80)
                                                  : $urandom_range(0, 16);
                pkt_put(8'(pl));
                repeat (pl) pkt_put(8'($urandom_range(0, 255)));
                pkt_q.push_back(pkt_crc[7:0]);
                pkt_q.push_back(pkt_crc[15:8]);
                if (sel >= 60 && sel < 72) begin
                    k = $urandom_range(2, pkt_q.size() - 1);
                    pkt_q[k] = pkt_q[k] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
        end else if (sel < 92) begin
            pkt_q.delete();
            repeat ($urandom_range(1, 6)) pkt_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            // good first byte, bad second byte
            pkt_q.delete();
            pkt_q.push_back(cfd_pkg::MAGIC_FIRST);
            k = $urandom_range(0, 255);
            if (k == int'(cfd_pkg::MAGIC_SEC_A) || k == int'(cfd_pkg::MAGIC_SEC_B))
                k = int'(cfd_pkg::MAGIC_FIRST);
            pkt_q.push_back(8'(k));
        end
        n_send = pkt_q.size();
        if (sel >= 72 && sel < 80 && piece != 20 && piece != 40)
            n_send = $urandom_range(1, pkt_q.size() - 1);
        for (k = 0; k < n_send; k++) offer_byte(pkt_q[k]);
    endtask

    // Event receiver: changing stall patterns plus one long hold-off
    initial begin
        int mode;
        int span;
        int phase;
        int hold_left;
        phase = 0;
        hold_left = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 256);
            repeat (span) begin
                @(negedge i_clk);
                phase++;
                if (hold_left > 0) begin
                    i_ev_ready <= 1'b0;
                    hold_left--;
                    if (hold_left == 0) hold_done = 1'b1;
                end else if (hold_req && !hold_done) begin
                    i_ev_ready <= 1'b0;
                    hold_left = 299;
                end else begin
                    case (mode)
                        0: i_ev_ready <= 1'b1;
                        1: i_ev_ready <= 1'($urandom_range(0, 1));
                        2: i_ev_ready <= ($urandom_range(0, 3) == 0);
                        default: i_ev_ready <= (phase % 4 != 3);
                    endcase
                end
            end
        end
    end

    // Event checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_ev_valid && i_ev_ready) begin
            if (due_events.size() == 0) begin
                mismatch("event with nothing pending, code", int'(o_event_res), 0);
            end else begin
                want_ev = due_events.pop_front();
                n_checked++;
                if (o_event_res != want_ev.code)
                    mismatch("event_res", int'(o_event_res), int'(want_ev.code));
                if (o_length != want_ev.len)
                    mismatch("length", int'(o_length), int'(want_ev.len));
                if (o_last != want_ev.last)
                    mismatch("last", int'(o_last), int'(want_ev.last));
                if (o_frames_ok != want_ev.n_ok)
                    mismatch("frames_ok", int'(o_frames_ok), int'(want_ev.n_ok));
                if (o_magic_errors != want_ev.n_magic)
                    mismatch("magic_errors", int'(o_magic_errors), int'(want_ev.n_magic));
                if (o_crc_errors != want_ev.n_crc)
                    mismatch("crc_errors", int'(o_crc_errors), int'(want_ev.n_crc));
                if (o_length_errors != want_ev.n_toolong)
                    mismatch("length_errors", int'(o_length_errors),
                             int'(want_ev.n_toolong));
                if (o_full_errors != want_ev.n_full)
                    mismatch("full_errors", int'(o_full_errors), int'(want_ev.n_full));
            end
        end
    end

    // Run limit
    initial begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus
    initial begin
        t_row       row;
        logic [7:0] b;
        int         before_n;
        t_ev_rec    e;
        int         piece;

        restart_frame();
        dropped = 0;
        cnt_ok = 16'h0000;
        cnt_magic = 16'h0000;
        cnt_crc = 16'h0000;
        cnt_toolong = 16'h0000;
        cnt_full = 16'h0000;
        pkt_crc = cfd_pkg::CRC_INIT;

        // header-only frame, good CRC
        add_row(B_LIT, 8'h01, 1'b1, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h64, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_CRC_LO, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_CRC_HI, 8'h00, 1'b0, 1'b1, cfd_pkg::EV_OK, 6);
        // bad first byte, then a bad second byte that is itself 0x01
        add_row(B_LIT, 8'hFF, 1'b1, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h01, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h01, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        // the next good start reports the dropped run, then a zero-payload frame
        add_row(B_LIT, 8'h01, 1'b1, 1'b1, cfd_pkg::EV_DROPPED, 2);
        add_row(B_LIT, 8'h65, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'hFF, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'hFF, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_CRC_LO, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_CRC_HI, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        // header-only frame with bad CRC: 0xFF length byte is too long
        add_row(B_LIT, 8'h01, 1'b1, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h64, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'hFF, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'hFF, 1'b0, 1'b1, cfd_pkg::EV_LONG, 6);
        // zero-payload frame with a zero CRC
        add_row(B_LIT, 8'h01, 1'b1, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h64, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);
        add_row(B_LIT, 8'h00, 1'b0, 1'b0, cfd_pkg::EV_OK, 0);

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < dir_rows.size(); r++) begin
            row = dir_rows[r];
            if (row.sof) pkt_crc = cfd_pkg::CRC_INIT;
            case (row.kind)
                B_CRC_LO: b = pkt_crc[7:0];
                B_CRC_HI: b = pkt_crc[15:8];
                default: begin
                    b = row.val;
                    pkt_crc = crc16_step(pkt_crc, b);
                end
            endcase
            before_n = n_pushed;
            offer_byte(b);
            if (row.chk) begin
                if (n_pushed > before_n) begin
                    e = due_events.pop_back();
                end else begin
                    e.last = 1'b1;
                    e.n_ok = cnt_ok;
                    e.n_magic = cnt_magic;
                    e.n_crc = cnt_crc;
                    e.n_toolong = cnt_toolong;
                    e.n_full = cnt_full;
                end
                e.code = row.code;
                e.len = row.len;
                due_events.push_back(e);
            end
        end

        // random stream
        piece = 0;
        while (n_bytes < 1050) begin
            random_piece(piece);
            piece++;
        end
        @(negedge i_clk);
        i_rx_valid <= 1'b0;

        // drain
        while (due_events.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);

        $display("sent %0d bytes in %0d random chunks, checked %0d event transfers",
                 n_bytes, piece, n_checked);
        $display("frames ok %0d, start-byte errors %0d, crc errors %0d, too long %0d",
                 cnt_ok, cnt_magic, cnt_crc, cnt_toolong);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/cfd_pkg.sv
rtl/core/cfd_front.sv
rtl/core/cfd_queue.sv
rtl/core/cfd_back.sv
rtl/core/crc16_framed_byte_deframer.sv
bench/tb_top.sv
